// ===== rtl/vumph_pkg.sv =====
// Package for the VU meter peak-hold block: widths, register codes,
// configuration struct and the raw-to-Q16 target function.
// No dependencies.
`default_nettype none

package vumph_pkg;

   // Fixed field widths
   localparam int IN_LANES    = 4;
   localparam int LANES_DEF   = 4;
   localparam int RAW_W       = 16;
   localparam int DT_W        = 20;
   localparam int Q16_W       = 17;
   localparam int TIME_W      = 24;
   localparam int DECAY_W     = 16;
   localparam int CLAMP_W     = 12;
   localparam int TGT_SHIFT   = 5;
   localparam int DECAY_SHIFT = 10;
   localparam int PROD_W      = Q16_W + DT_W;
   localparam int FALL_W      = DT_W + DECAY_W - DECAY_SHIFT;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CLAMP_W-1:0] FULL_RAW = CLAMP_W'(2048);
   localparam logic [TIME_W-1:0]  HOLD_MAX = {TIME_W{1'b1}};

   // Register reset values
   localparam logic [TIME_W-1:0]  RELEASE_RST = TIME_W'(300000);
   localparam logic [TIME_W-1:0]  HOLD_RST    = TIME_W'(1000000);
   localparam logic [DECAY_W-1:0] DECAY_RST   = DECAY_W'(32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RELEASE = 2'd0,
      CSR_HOLD    = 2'd1,
      CSR_DECAY   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0]  release_us;
      logic [TIME_W-1:0]  hold_us;
      logic [DECAY_W-1:0] decay;
   } cfg_type;

   // Clamp a raw magnitude at full scale and scale it to Q16
   function automatic logic [Q16_W-1:0] target_of(input logic [RAW_W-1:0] raw);
      logic [CLAMP_W-1:0] clamped;
      clamped = (raw > RAW_W'(FULL_RAW)) ? FULL_RAW : raw[CLAMP_W-1:0];
      return {clamped, {TGT_SHIFT{1'b0}}};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/vumph_if.sv =====
// Channel interfaces of the VU meter peak-hold block: tick request and
// level/peak response, each with valid/ready. Depends on vumph_pkg.
`default_nettype none

interface vumph_req_if;
   import vumph_pkg::*;
   logic               valid;
   logic               ready;
   logic [RAW_W-1:0]   raw_peak_a_pos;
   logic [RAW_W-1:0]   raw_peak_a_neg;
   logic [RAW_W-1:0]   raw_peak_b_pos;
   logic [RAW_W-1:0]   raw_peak_b_neg;
   logic [DT_W-1:0]    elapsed_us;

   modport source (output valid, raw_peak_a_pos, raw_peak_a_neg, raw_peak_b_pos,
                   raw_peak_b_neg, elapsed_us, input ready);
   modport sink   (input valid, raw_peak_a_pos, raw_peak_a_neg, raw_peak_b_pos,
                   raw_peak_b_neg, elapsed_us, output ready);
endinterface

interface vumph_rsp_if;
   import vumph_pkg::*;
   logic               valid;
   logic               ready;
   logic [Q16_W-1:0]   lvl_a_pos;
   logic [Q16_W-1:0]   lvl_a_neg;
   logic [Q16_W-1:0]   lvl_b_pos;
   logic [Q16_W-1:0]   lvl_b_neg;
   logic [Q16_W-1:0]   held_peak_a_pos;
   logic [Q16_W-1:0]   held_peak_a_neg;
   logic [Q16_W-1:0]   held_peak_b_pos;
   logic [Q16_W-1:0]   held_peak_b_neg;

   modport source (output valid, lvl_a_pos, lvl_a_neg, lvl_b_pos, lvl_b_neg,
                   held_peak_a_pos, held_peak_a_neg, held_peak_b_pos, held_peak_b_neg,
                   input ready);
   modport sink   (input valid, lvl_a_pos, lvl_a_neg, lvl_b_pos, lvl_b_neg,
                   held_peak_a_pos, held_peak_a_neg, held_peak_b_pos, held_peak_b_neg,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/vumph_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the level release step.
// No package dependency.
`default_nettype none

module vumph_divider #(
   parameter int DIVIDEND_W = 37,
   parameter int DIVISOR_W  = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  qbit;

   // One trial subtraction per cycle
   always_comb begin
      trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      qbit  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(DIVIDEND_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         quot_in = {quot_ff[DIVIDEND_W-2:0], qbit};
         rem_in  = qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/vumph_lane.sv =====
// One meter lane: level with instant attack and divided release, peak with
// hold timer and linear decay. Depends on vumph_pkg and vumph_divider.
`default_nettype none

module vumph_lane (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [vumph_pkg::Q16_W-1:0] target,
   input  wire logic [vumph_pkg::DT_W-1:0]  dt,
   input  wire vumph_pkg::cfg_type         cfg,
   output logic                           done,
   output logic [vumph_pkg::Q16_W-1:0]    level,
   output logic [vumph_pkg::Q16_W-1:0]    peak
);
   import vumph_pkg::*;

   typedef enum logic [2:0] {
      L_IDLE = 3'b001,
      L_MUL  = 3'b010,
      L_DIV  = 3'b100
   } lane_state_type;

   lane_state_type     state_ff, state_in;
   logic [Q16_W-1:0]   level_ff, level_in;
   logic [Q16_W-1:0]   peak_ff, peak_in;
   logic [TIME_W-1:0]  hold_ff, hold_in;
   logic [Q16_W-1:0]   target_ff;
   logic [DT_W-1:0]    dt_ff;
   logic [FALL_W-1:0]  fall_ff;
   logic               done_ff, done_in;

   logic [Q16_W-1:0]   gap;
   logic [PROD_W-1:0]  prod;
   logic [DT_W+DECAY_W-1:0] fall_full;
   logic [TIME_W-1:0]  rel;
   logic               div_start;
   logic               div_done;
   logic [PROD_W-1:0]  step;
   logic [TIME_W:0]    hold_sum;
   logic [TIME_W-1:0]  hold_sat;

   // Distance above target, and the two products
   always_comb begin
      gap       = (target_ff > level_ff) ? '0 : level_ff - target_ff;
      prod      = PROD_W'(gap) * PROD_W'(dt_ff);
      fall_full = (DT_W+DECAY_W)'(dt_ff) * (DT_W+DECAY_W)'(cfg.decay);
      rel       = (cfg.release_us == '0) ? TIME_W'(1) : cfg.release_us;
      div_start = (state_ff == L_MUL);
      hold_sum  = {1'b0, hold_ff} + (TIME_W+1)'(dt_ff);
      hold_sat  = hold_sum[TIME_W] ? HOLD_MAX : hold_sum[TIME_W-1:0];
   end

   vumph_divider #(
      .DIVIDEND_W (PROD_W),
      .DIVISOR_W  (TIME_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod),
      .divisor  (rel),
      .done     (div_done),
      .quotient (step)
   );

   // Sequence the lane and commit the new state when the quotient lands
   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      peak_in  = peak_ff;
      hold_in  = hold_ff;
      done_in  = 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               state_in = L_MUL;
            end
         end
         L_MUL: begin
            state_in = L_DIV;
         end
         L_DIV: begin
            if (div_done) begin
               state_in = L_IDLE;
               done_in  = 1'b1;
               // level: jump up, otherwise release by the truncated step
               if (target_ff > level_ff) begin
                  level_in = target_ff;
               end else if (step >= PROD_W'(level_ff)) begin
                  level_in = '0;
               end else begin
                  level_in = level_ff - step[Q16_W-1:0];
               end
               // peak: capture and restart hold, or age and decay
               if (target_ff > peak_ff) begin
                  peak_in = target_ff;
                  hold_in = '0;
               end else begin
                  hold_in = hold_sat;
                  if (hold_sat > cfg.hold_us) begin
                     if (fall_ff >= FALL_W'(peak_ff)) begin
                        peak_in = '0;
                     end else begin
                        peak_in = peak_ff - fall_ff[Q16_W-1:0];
                     end
                  end
               end
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         level_ff <= '0;
         peak_ff  <= '0;
         hold_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         peak_ff  <= peak_in;
         hold_ff  <= hold_in;
         done_ff  <= done_in;
      end
   end

   // Latch the beat operands and the registered decay product
   always_ff @(posedge clock) begin
      if (start && state_ff == L_IDLE) begin
         target_ff <= target;
         dt_ff     <= dt;
      end
      if (state_ff == L_MUL) begin
         fall_ff <= fall_full[DT_W+DECAY_W-1:DECAY_SHIFT];
      end
   end

   assign done  = done_ff;
   assign level = level_ff;
   assign peak  = peak_ff;

endmodule

`default_nettype wire

// ===== rtl/vu_meter_peak_hold.sv =====
// VU meter with fast attack, slow release and peak hold.
// Usage:
//   req_bus carries one tick: four raw peak magnitudes (2048 = full scale)
//   and elapsed_us. rsp_bus returns one beat per tick with four Q16 levels
//   and four held peaks (65536 = full scale).
//   csr_we/csr_index/csr_wdata write release time, hold time and decay
//   rate; write only while no tick is in flight. Unknown indexes are dropped.
// Tick sequence:
//   From acceptance to response valid, a tick goes through these steps: the
//   products are formed, each lane's bit-serial divider works out the
//   release step, the lane state is committed and the output register is
//   loaded. One tick is in flight at a time and ready returns with the load,
//   so a new tick is not taken before the last one is through its lanes.
//   Active lanes, up to four, run in parallel, each with its own divider.
// Reset: levels, peaks and hold timers clear to zero; registers return to
//   300000 us release, 1000000 us hold, decay 32768.
// Stall: the response sits in an output register. A new tick is accepted
//   while it waits; if it finishes before the old beat is taken, it holds
//   until the register frees.
// Depends on vumph_pkg, vumph_if, vumph_lane.
`default_nettype none

module vu_meter_peak_hold #(
   parameter int LANES = vumph_pkg::LANES_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   vumph_req_if.sink                           req_bus,
   vumph_rsp_if.source                         rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [vumph_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [vumph_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import vumph_pkg::*;

   localparam int NUM_ACTIVE = (LANES < IN_LANES) ? LANES : IN_LANES;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_PUSH = 3'b100
   } top_state_type;

   top_state_type      state_ff, state_in;
   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [Q16_W-1:0]   out_level_ff [IN_LANES];
   logic [Q16_W-1:0]   out_peak_ff  [IN_LANES];

   logic               accept;
   logic               slot_free;
   logic               load;
   logic               lanes_done;
   logic [RAW_W-1:0]   raw       [IN_LANES];
   logic [Q16_W-1:0]   lane_level [IN_LANES];
   logic [Q16_W-1:0]   lane_peak  [IN_LANES];
   logic [IN_LANES-1:0] lane_done;

   assign accept = req_bus.valid && req_bus.ready;
   assign raw[0] = req_bus.raw_peak_a_pos;
   assign raw[1] = req_bus.raw_peak_a_neg;
   assign raw[2] = req_bus.raw_peak_b_pos;
   assign raw[3] = req_bus.raw_peak_b_neg;

   // Lanes side by side; absent lanes read as zero
   for (genvar k = 0; k < IN_LANES; k++) begin : g_lane
      if (k < NUM_ACTIVE) begin : g_on
         vumph_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .start  (accept),
            .target (target_of(raw[k])),
            .dt     (req_bus.elapsed_us),
            .cfg    (cfg_ff),
            .done   (lane_done[k]),
            .level  (lane_level[k]),
            .peak   (lane_peak[k])
         );
      end else begin : g_off
         assign lane_done[k]  = 1'b1;
         assign lane_level[k] = '0;
         assign lane_peak[k]  = '0;
      end
   end

   assign lanes_done = &lane_done;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_RELEASE: cfg_in.release_us = csr_wdata[TIME_W-1:0];
            CSR_HOLD:    cfg_in.hold_us    = csr_wdata[TIME_W-1:0];
            CSR_DECAY:   cfg_in.decay      = csr_wdata[DECAY_W-1:0];
            default:     cfg_in            = cfg_ff;
         endcase
      end
   end

   // Tick sequencing and merge into the output register
   always_comb begin
      slot_free    = !rsp_valid_ff || rsp_bus.ready;
      state_in     = state_ff;
      load         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (lanes_done) begin
               if (slot_free) begin
                  load     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            if (slot_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         cfg_ff.release_us <= RELEASE_RST;
         cfg_ff.hold_us    <= HOLD_RST;
         cfg_ff.decay      <= DECAY_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_level_ff <= lane_level;
         out_peak_ff  <= lane_peak;
      end
   end

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.lvl_a_pos       = out_level_ff[0];
   assign rsp_bus.lvl_a_neg       = out_level_ff[1];
   assign rsp_bus.lvl_b_pos       = out_level_ff[2];
   assign rsp_bus.lvl_b_neg       = out_level_ff[3];
   assign rsp_bus.held_peak_a_pos = out_peak_ff[0];
   assign rsp_bus.held_peak_a_neg = out_peak_ff[1];
   assign rsp_bus.held_peak_b_pos = out_peak_ff[2];
   assign rsp_bus.held_peak_b_neg = out_peak_ff[3];

   // Lane 0 finishes only while a tick is running
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> (state_ff == S_RUN))
      else $error("lane finished outside a running tick");

   // A new response beat only follows a tick that was running
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RUN || $past(state_ff) == S_PUSH))
      else $error("response raised without a tick");

   // Levels and peaks of lanes 0 and 3 stay within full scale
   a_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_level_ff[0] <= Q16_W'(65536) && out_peak_ff[0] <= Q16_W'(65536)
                        && out_level_ff[3] <= Q16_W'(65536)
                        && out_peak_ff[3] <= Q16_W'(65536)))
      else $error("level or peak above full scale");

endmodule

`default_nettype wire
